>>> rtl/mep_pkg.sv
package mep_pkg;

    // number format: signed Q4.FRAC_BITS
    localparam int FRAC_BITS = 28;
    localparam int QW        = FRAC_BITS + 4;
    // truncated products and sums before saturation
    localparam int PRW       = QW + 8;

    // field widths
    localparam int PW        = 12;
    localparam int SIDE_W    = 13;
    localparam int GW        = 16;
    localparam int MAX_SIDE  = 4096;

    // divider widths: mapping numerator is (col*7 or row*2) << FRAC_BITS, gray numerator count*gray
    localparam int MAP_W     = PW + 3;
    localparam int NUM_W     = (MAP_W + FRAC_BITS > 2 * GW) ? MAP_W + FRAC_BITS : 2 * GW;
    localparam int DEN_W     = GW;
    localparam int CNT_W     = $clog2(NUM_W + 1);

    // fixed-point constants
    localparam logic signed [PRW-1:0] Q_MAX  = (PRW'(1) << (QW - 1)) - PRW'(1);
    localparam logic signed [PRW-1:0] Q_MIN  = -(PRW'(1) << (QW - 1));
    localparam logic signed [PRW-1:0] OFF_RE = PRW'(5) << (FRAC_BITS - 1);
    localparam logic signed [PRW-1:0] OFF_IM = PRW'(1) << FRAC_BITS;
    localparam logic signed [PRW-1:0] FOUR   = PRW'(4) << FRAC_BITS;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd3;

    // datapath operations
    localparam logic [3:0] OP_NOP      = 4'd0;
    localparam logic [3:0] OP_LATCH    = 4'd1;
    localparam logic [3:0] OP_DIV_RE   = 4'd2;
    localparam logic [3:0] OP_SET_RE   = 4'd3;
    localparam logic [3:0] OP_DIV_IM   = 4'd4;
    localparam logic [3:0] OP_SET_IM   = 4'd5;
    localparam logic [3:0] OP_MUL      = 4'd6;
    localparam logic [3:0] OP_ITER     = 4'd7;
    localparam logic [3:0] OP_SCALE    = 4'd8;
    localparam logic [3:0] OP_DIV_GRAY = 4'd9;
    localparam logic [3:0] OP_OUT      = 4'd10;

    // jump conditions
    localparam logic [2:0] CND_NEVER      = 3'd0;
    localparam logic [2:0] CND_ALWAYS     = 3'd1;
    localparam logic [2:0] CND_NO_START   = 3'd2;
    localparam logic [2:0] CND_DIV_BUSY   = 3'd3;
    localparam logic [2:0] CND_ITER_GO    = 3'd4;
    localparam logic [2:0] CND_LIMIT_ZERO = 3'd5;

    // program steps
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] ST_DIV_RE   = 4'd1;
    localparam logic [PC_W-1:0] ST_WAIT_RE  = 4'd2;
    localparam logic [PC_W-1:0] ST_SET_RE   = 4'd3;
    localparam logic [PC_W-1:0] ST_DIV_IM   = 4'd4;
    localparam logic [PC_W-1:0] ST_WAIT_IM  = 4'd5;
    localparam logic [PC_W-1:0] ST_SET_IM   = 4'd6;
    localparam logic [PC_W-1:0] ST_MUL      = 4'd7;
    localparam logic [PC_W-1:0] ST_ITER     = 4'd8;
    localparam logic [PC_W-1:0] ST_SCALE    = 4'd9;
    localparam logic [PC_W-1:0] ST_DIV_GRAY = 4'd10;
    localparam logic [PC_W-1:0] ST_WAIT_GR  = 4'd11;
    localparam logic [PC_W-1:0] ST_OUT      = 4'd12;

    typedef struct packed {
        logic [3:0]      op;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic div_busy;
        logic iter_go;
        logic limit_zero;
    } t_status;

    typedef struct packed {
        logic [PW-1:0] pixel_row;
        logic [PW-1:0] pixel_col;
    } t_pixel;

    typedef struct packed {
        logic [GW-1:0] pixel_gray;
        logic [GW-1:0] escape_count;
    } t_result;

    typedef struct packed {
        logic [SIDE_W-1:0] image_width;
        logic [SIDE_W-1:0] image_height;
        logic [GW-1:0]     gray_maximum;
        logic [GW-1:0]     iteration_limit;
    } t_cfg;

    // control store: a step jumps to target when its condition holds, else falls through
    function automatic t_uword prog_word(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_NOP, cond: CND_ALWAYS, target: ST_IDLE};
        case (pc)
            ST_IDLE:     w = '{op: OP_LATCH,    cond: CND_NO_START,   target: ST_IDLE};
            ST_DIV_RE:   w = '{op: OP_DIV_RE,   cond: CND_NEVER,      target: ST_IDLE};
            ST_WAIT_RE:  w = '{op: OP_NOP,      cond: CND_DIV_BUSY,   target: ST_WAIT_RE};
            ST_SET_RE:   w = '{op: OP_SET_RE,   cond: CND_NEVER,      target: ST_IDLE};
            ST_DIV_IM:   w = '{op: OP_DIV_IM,   cond: CND_NEVER,      target: ST_IDLE};
            ST_WAIT_IM:  w = '{op: OP_NOP,      cond: CND_DIV_BUSY,   target: ST_WAIT_IM};
            ST_SET_IM:   w = '{op: OP_SET_IM,   cond: CND_NEVER,      target: ST_IDLE};
            ST_MUL:      w = '{op: OP_MUL,      cond: CND_NEVER,      target: ST_IDLE};
            ST_ITER:     w = '{op: OP_ITER,     cond: CND_ITER_GO,    target: ST_MUL};
            ST_SCALE:    w = '{op: OP_SCALE,    cond: CND_LIMIT_ZERO, target: ST_OUT};
            ST_DIV_GRAY: w = '{op: OP_DIV_GRAY, cond: CND_NEVER,      target: ST_IDLE};
            ST_WAIT_GR:  w = '{op: OP_NOP,      cond: CND_DIV_BUSY,   target: ST_WAIT_GR};
            ST_OUT:      w = '{op: OP_OUT,      cond: CND_ALWAYS,     target: ST_IDLE};
            default:     w = '{op: OP_NOP,      cond: CND_ALWAYS,     target: ST_IDLE};
        endcase
        return w;
    endfunction

    // clamp to the Q4 range
    function automatic logic signed [QW-1:0] sat_q(input logic signed [PRW-1:0] v);
        logic signed [PRW-1:0] r;
        r = v;
        if (v > Q_MAX) begin
            r = Q_MAX;
        end else if (v < Q_MIN) begin
            r = Q_MIN;
        end
        return QW'(r);
    endfunction

endpackage

>>> rtl/mandelbrot_escape_pixel.sv
// Mandelbrot escape-time unit for one pixel.
// Pixel channel: present the row and column on i_pixel and raise start; the
// beat is taken at a rising edge with start high and busy low. busy stays high
// while the pixel is worked on.
// Result channel: o_done is high for exactly one cycle with gray level and
// escape count on o_result; the receiver cannot stall, so it must take the
// beat in that cycle. The next pixel may be started in that same cycle.
// Configuration: i_cfg_valid with i_cfg_index and i_cfg_data writes width,
// height, gray maximum or iteration limit; o_cfg_ready is always high. Write
// only while busy is low.
// Each iteration is two control steps, products then escape test and update,
// and the test that ends the loop costs one more pair. The rest is four single
// steps plus three divides on the shared bit-serial divider (real part,
// imaginary part, gray scaling; the gray divide is skipped when the iteration
// limit is zero), each a load step and a wait step that holds while the divider
// is busy. One pixel at a time.
// Reset returns the sequencer to idle, drops o_done and loads the registers
// with width 1000, height 1000, gray maximum 255 and iteration limit 1000.
module mandelbrot_escape_pixel (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  mep_pkg::t_pixel                   i_pixel,
    output logic                              o_done,
    output mep_pkg::t_result                  o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mep_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mep_pkg::GW-1:0]            i_cfg_data
);

    logic [mep_pkg::SIDE_W-1:0] r_image_width;
    logic [mep_pkg::SIDE_W-1:0] r_image_height;
    logic [mep_pkg::GW-1:0]     r_gray_maximum;
    logic [mep_pkg::GW-1:0]     r_iteration_limit;
    mep_pkg::t_cfg              cfg;
    mep_pkg::t_uword            uword;
    mep_pkg::t_status           status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width     <= mep_pkg::SIDE_W'(1000);
            r_image_height    <= mep_pkg::SIDE_W'(1000);
            r_gray_maximum    <= mep_pkg::GW'(255);
            r_iteration_limit <= mep_pkg::GW'(1000);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                mep_pkg::REG_WIDTH:  r_image_width     <= i_cfg_data[mep_pkg::SIDE_W-1:0];
                mep_pkg::REG_HEIGHT: r_image_height    <= i_cfg_data[mep_pkg::SIDE_W-1:0];
                mep_pkg::REG_GRAY:   r_gray_maximum    <= i_cfg_data;
                mep_pkg::REG_LIMIT:  r_iteration_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign cfg = '{image_width:     r_image_width,
                   image_height:    r_image_height,
                   gray_maximum:    r_gray_maximum,
                   iteration_limit: r_iteration_limit};

    // control store and step counter
    mep_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_uword  (uword),
        .o_busy   (busy)
    );

    // mapping, iteration and scaling datapath
    mep_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_uword  (uword),
        .i_pixel  (i_pixel),
        .i_cfg    (cfg),
        .o_status (status),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // a result beat appears only once the sequencer is back in idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while sequencer busy");

    // an accepted pixel always starts the program
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted pixel did not start the sequencer");

    // the result strobe drops again after each beat
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

endmodule

>>> rtl/mep_divider.sv
module mep_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [mep_pkg::NUM_W-1:0]  i_num,
    input  logic [mep_pkg::DEN_W-1:0]  i_den,
    output logic                       o_busy,
    output logic [mep_pkg::NUM_W-1:0]  o_quot
);

    logic [mep_pkg::CNT_W-1:0] r_cnt;
    logic [mep_pkg::NUM_W-1:0] r_quo;
    logic [mep_pkg::DEN_W-1:0] r_rem;
    logic [mep_pkg::DEN_W-1:0] r_den;
    logic [mep_pkg::DEN_W:0]   trial;
    logic                      fits;

    // one quotient bit per cycle, restoring
    assign trial = {r_rem, r_quo[mep_pkg::NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= mep_pkg::CNT_W'(mep_pkg::NUM_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - mep_pkg::CNT_W'(1);
        end
    end

    // numerator shifts out at the top, quotient shifts in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (o_busy) begin
            r_quo <= {r_quo[mep_pkg::NUM_W-2:0], fits};
            r_rem <= fits ? mep_pkg::DEN_W'(trial - {1'b0, r_den})
                          : mep_pkg::DEN_W'(trial);
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quo;

endmodule

>>> rtl/mep_sequencer.sv
module mep_sequencer (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  mep_pkg::t_status         i_status,
    output mep_pkg::t_uword          o_uword,
    output logic                     o_busy
);

    logic [mep_pkg::PC_W-1:0] r_pc;
    logic [mep_pkg::PC_W-1:0] n_pc;
    mep_pkg::t_uword          uword;
    logic                     taken;

    // fetch from the control store
    assign uword = mep_pkg::prog_word(r_pc);

    // evaluate the jump condition
    always_comb begin
        case (uword.cond)
            mep_pkg::CND_NEVER:      taken = 1'b0;
            mep_pkg::CND_ALWAYS:     taken = 1'b1;
            mep_pkg::CND_NO_START:   taken = !i_start;
            mep_pkg::CND_DIV_BUSY:   taken = i_status.div_busy;
            mep_pkg::CND_ITER_GO:    taken = i_status.iter_go;
            mep_pkg::CND_LIMIT_ZERO: taken = i_status.limit_zero;
            default:                 taken = 1'b1;
        endcase
        n_pc = taken ? uword.target : r_pc + mep_pkg::PC_W'(1);
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= mep_pkg::ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = uword;
    assign o_busy  = r_pc != mep_pkg::ST_IDLE;

endmodule

>>> rtl/mep_datapath.sv
module mep_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mep_pkg::t_uword  i_uword,
    input  mep_pkg::t_pixel  i_pixel,
    input  mep_pkg::t_cfg    i_cfg,
    output mep_pkg::t_status o_status,
    output logic             o_done,
    output mep_pkg::t_result o_result
);

    logic [mep_pkg::PW-1:0]           r_row;
    logic [mep_pkg::PW-1:0]           r_col;
    logic signed [mep_pkg::QW-1:0]    r_cre;
    logic signed [mep_pkg::QW-1:0]    r_cim;
    logic signed [mep_pkg::QW-1:0]    r_x;
    logic signed [mep_pkg::QW-1:0]    r_y;
    logic signed [mep_pkg::PRW-1:0]   r_xx;
    logic signed [mep_pkg::PRW-1:0]   r_yy;
    logic signed [mep_pkg::PRW-1:0]   r_xy2;
    logic [mep_pkg::GW-1:0]           r_count;
    logic [2*mep_pkg::GW-1:0]         r_prod;
    logic                             r_done;
    mep_pkg::t_result                 r_result;

    logic [mep_pkg::SIDE_W-1:0]       w_eff;
    logic [mep_pkg::SIDE_W-1:0]       h_eff;
    logic [mep_pkg::MAP_W-1:0]        map_re;
    logic [mep_pkg::MAP_W-1:0]        map_im;
    logic                             div_start;
    logic [mep_pkg::NUM_W-1:0]        div_num;
    logic [mep_pkg::DEN_W-1:0]        div_den;
    logic                             div_busy;
    logic [mep_pkg::NUM_W-1:0]        div_quot;
    logic                             ratio_big;
    logic [mep_pkg::QW:0]             ratio;
    logic signed [mep_pkg::PRW-1:0]   ratio_s;
    logic signed [2*mep_pkg::QW-1:0]  px;
    logic signed [2*mep_pkg::QW-1:0]  py;
    logic signed [2*mep_pkg::QW-1:0]  pxy;
    logic signed [mep_pkg::PRW-1:0]   mag;
    logic                             escape;
    logic                             iter_go;
    logic                             limit_zero;
    logic [mep_pkg::GW-1:0]           scaled;

    // clamp image sides to 1..MAX_SIDE
    always_comb begin
        w_eff = i_cfg.image_width;
        if (i_cfg.image_width == '0) begin
            w_eff = mep_pkg::SIDE_W'(1);
        end else if (i_cfg.image_width > mep_pkg::SIDE_W'(mep_pkg::MAX_SIDE)) begin
            w_eff = mep_pkg::SIDE_W'(mep_pkg::MAX_SIDE);
        end
        h_eff = i_cfg.image_height;
        if (i_cfg.image_height == '0) begin
            h_eff = mep_pkg::SIDE_W'(1);
        end else if (i_cfg.image_height > mep_pkg::SIDE_W'(mep_pkg::MAX_SIDE)) begin
            h_eff = mep_pkg::SIDE_W'(mep_pkg::MAX_SIDE);
        end
    end

    // re = col*7 / (2*width), im = row*2 / height, both scaled by 2^FRAC_BITS
    assign map_re = mep_pkg::MAP_W'(r_col) * mep_pkg::MAP_W'(7);
    assign map_im = mep_pkg::MAP_W'({r_row, 1'b0});

    // divider operand select
    always_comb begin
        div_start = 1'b0;
        div_num   = mep_pkg::NUM_W'(r_prod);
        div_den   = i_cfg.iteration_limit;
        case (i_uword.op)
            mep_pkg::OP_DIV_RE: begin
                div_start = 1'b1;
                div_num   = mep_pkg::NUM_W'({map_re, {mep_pkg::FRAC_BITS{1'b0}}});
                div_den   = mep_pkg::DEN_W'({w_eff, 1'b0});
            end
            mep_pkg::OP_DIV_IM: begin
                div_start = 1'b1;
                div_num   = mep_pkg::NUM_W'({map_im, {mep_pkg::FRAC_BITS{1'b0}}});
                div_den   = mep_pkg::DEN_W'(h_eff);
            end
            mep_pkg::OP_DIV_GRAY: begin
                div_start = 1'b1;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    mep_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // mapped ratio capped at 16.0
    assign ratio_big = |div_quot[mep_pkg::NUM_W-1:mep_pkg::QW];
    assign ratio     = ratio_big ? {1'b1, {mep_pkg::QW{1'b0}}}
                                 : {1'b0, div_quot[mep_pkg::QW-1:0]};
    assign ratio_s   = mep_pkg::PRW'(ratio);

    // full-width products, floored to the fraction
    assign px  = r_x * r_x;
    assign py  = r_y * r_y;
    assign pxy = r_x * r_y;

    // escape and limit test
    assign mag        = r_xx + r_yy;
    assign escape     = mag > mep_pkg::FOUR;
    assign iter_go    = (r_count < i_cfg.iteration_limit) && !escape;
    assign limit_zero = i_cfg.iteration_limit == '0;
    assign scaled     = limit_zero ? '0 : div_quot[mep_pkg::GW-1:0];

    // datapath registers, one operation per step
    always_ff @(posedge i_clk) begin
        case (i_uword.op)
            mep_pkg::OP_LATCH: begin
                r_row <= i_pixel.pixel_row;
                r_col <= i_pixel.pixel_col;
            end
            mep_pkg::OP_SET_RE: begin
                r_cre <= mep_pkg::sat_q(ratio_s - mep_pkg::OFF_RE);
            end
            mep_pkg::OP_SET_IM: begin
                r_cim   <= mep_pkg::sat_q(ratio_s - mep_pkg::OFF_IM);
                r_x     <= '0;
                r_y     <= '0;
                r_count <= '0;
            end
            mep_pkg::OP_MUL: begin
                r_xx  <= mep_pkg::PRW'(px >>> mep_pkg::FRAC_BITS);
                r_yy  <= mep_pkg::PRW'(py >>> mep_pkg::FRAC_BITS);
                r_xy2 <= mep_pkg::PRW'(pxy >>> (mep_pkg::FRAC_BITS - 1));
            end
            mep_pkg::OP_ITER: begin
                if (iter_go) begin
                    r_x     <= mep_pkg::sat_q(r_xx - r_yy + mep_pkg::PRW'(r_cre));
                    r_y     <= mep_pkg::sat_q(r_xy2 + mep_pkg::PRW'(r_cim));
                    r_count <= r_count + mep_pkg::GW'(1);
                end
            end
            mep_pkg::OP_SCALE: begin
                r_prod <= (2*mep_pkg::GW)'(r_count) * (2*mep_pkg::GW)'(i_cfg.gray_maximum);
            end
            mep_pkg::OP_OUT: begin
                r_result.pixel_gray   <= i_cfg.gray_maximum - scaled;
                r_result.escape_count <= r_count;
            end
            default: begin
            end
        endcase
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_uword.op == mep_pkg::OP_OUT;
        end
    end

    assign o_status = '{div_busy: div_busy, iter_go: iter_go, limit_zero: limit_zero};
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

>>> test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 200;
    localparam int GAP_PCT     = 32;

    typedef enum logic {DO_PIXEL, DO_WRITE} t_step_kind;

    // one row of the directed table; gray/count only used when known is set
    typedef struct packed {
        t_step_kind                    kind;
        logic [mep_pkg::CFG_IDX_W-1:0] idx;
        logic [mep_pkg::GW-1:0]        data;
        logic [mep_pkg::PW-1:0]        row;
        logic [mep_pkg::PW-1:0]        col;
        logic                          known;
        logic [mep_pkg::GW-1:0]        gray;
        logic [mep_pkg::GW-1:0]        count;
    } t_step;

    localparam int NUM_DIRECTED = 30;
    localparam t_step DIRECTED [NUM_DIRECTED] = '{
        // reset values: corner escapes at once, far corner saturates
        '{DO_PIXEL, mep_pkg::REG_WIDTH,  16'd0,    12'd0,    12'd0,    1'b1, 16'd255,   16'd1},
        '{DO_PIXEL, mep_pkg::REG_WIDTH,  16'd0,    12'd4095, 12'd4095, 1'b1, 16'd255,   16'd1},
        '{DO_PIXEL, mep_pkg::REG_WIDTH,  16'd0,    12'd500,  12'd714,  1'b0, 16'd0,     16'd0},
        '{DO_PIXEL, mep_pkg::REG_WIDTH,  16'd0,    12'd999,  12'd999,  1'b0, 16'd0,     16'd0},
        // zero iteration limit
        '{DO_WRITE, mep_pkg::REG_LIMIT,  16'd0,    12'd0,    12'd0,    1'b0, 16'd0,     16'd0},
        '{DO_PIXEL, mep_pkg::REG_WIDTH,  16'd0,    12'd0,    12'd0,    1'b1, 16'd255,   16'd0},
        '{DO_WRITE, mep_pkg::REG_GRAY,   16'hFFFF, 12'd0,    12'd0,    1'b0, 16'd0,     16'd0},
        '{DO_PIXEL, mep_pkg::REG_WIDTH,  16'd0,    12'd123,  12'd4095, 1'b1, 16'hFFFF,  16'd0},
        // tiny image whose pixel (1,5) sits exactly on the origin
        '{DO_WRITE, mep_pkg::REG_WIDTH,  16'd7,    12'd0,    12'd0,    1'b0, 16'd0,     16'd0},
        '{DO_WRITE, mep_pkg::REG_HEIGHT, 16'd2,    12'd0,    12'd0,    1'b0, 16'd0,     16'd0},
        '{DO_WRITE, mep_pkg::REG_LIMIT,  16'hFFFF, 12'd0,    12'd0,    1'b0, 16'd0,     16'd0},
        '{DO_PIXEL, mep_pkg::REG_WIDTH,  16'd0,    12'd1,    12'd5,    1'b1, 16'd0,     16'hFFFF},
        '{DO_PIXEL, mep_pkg::REG_WIDTH,  16'd0,    12'd0,    12'd0,    1'b1, 16'd65534, 16'd1},
        // zero sides are taken as one
        '{DO_WRITE, mep_pkg::REG_WIDTH,  16'd0,    12'd0,    12'd0,    1'b0, 16'd0,     16'd0},
        '{DO_WRITE, mep_pkg::REG_HEIGHT, 16'd0,    12'd0,    12'd0,    1'b0, 16'd0,     16'd0},
        '{DO_WRITE, mep_pkg::REG_LIMIT,  16'd1,    12'd0,    12'd0,    1'b0, 16'd0,     16'd0},
        '{DO_PIXEL, mep_pkg::REG_WIDTH,  16'd0,    12'd0,    12'd0,    1'b1, 16'd0,     16'd1},
        '{DO_PIXEL, mep_pkg::REG_WIDTH,  16'd0,    12'd1,    12'd1,    1'b0, 16'd0,     16'd0},
        // oversized sides are capped, gray maximum of zero
        '{DO_WRITE, mep_pkg::REG_WIDTH,  16'hFFFF, 12'd0,    12'd0,    1'b0, 16'd0,     16'd0},
        '{DO_WRITE, mep_pkg::REG_HEIGHT, 16'd4097, 12'd0,    12'd0,    1'b0, 16'd0,     16'd0},
        '{DO_WRITE, mep_pkg::REG_GRAY,   16'd0,    12'd0,    12'd0,    1'b0, 16'd0,     16'd0},
        '{DO_WRITE, mep_pkg::REG_LIMIT,  16'd2,    12'd0,    12'd0,    1'b0, 16'd0,     16'd0},
        '{DO_PIXEL, mep_pkg::REG_WIDTH,  16'd0,    12'd4095, 12'd4095, 1'b0, 16'd0,     16'd0},
        '{DO_PIXEL, mep_pkg::REG_WIDTH,  16'd0,    12'd2048, 12'd0,    1'b0, 16'd0,     16'd0},
        // largest regular image
        '{DO_WRITE, mep_pkg::REG_WIDTH,  16'd4096, 12'd0,    12'd0,    1'b0, 16'd0,     16'd0},
        '{DO_WRITE, mep_pkg::REG_HEIGHT, 16'd4096, 12'd0,    12'd0,    1'b0, 16'd0,     16'd0},
        '{DO_WRITE, mep_pkg::REG_GRAY,   16'h8000, 12'd0,    12'd0,    1'b0, 16'd0,     16'd0},
        '{DO_WRITE, mep_pkg::REG_LIMIT,  16'd7,    12'd0,    12'd0,    1'b0, 16'd0,     16'd0},
        '{DO_PIXEL, mep_pkg::REG_WIDTH,  16'd0,    12'd2048, 12'd2926, 1'b0, 16'd0,     16'd0},
        '{DO_PIXEL, mep_pkg::REG_WIDTH,  16'd0,    12'd0,    12'd4095, 1'b0, 16'd0,     16'd0}
    };

    logic                          i_clk;
    logic                          i_rst_n     = 1'b0;
    logic                          start       = 1'b0;
    logic                          busy;
    mep_pkg::t_pixel               i_pixel     = '0;
    logic                          o_done;
    mep_pkg::t_result              o_result;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [mep_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [mep_pkg::GW-1:0]        i_cfg_data  = '0;

    mep_pkg::t_cfg    shadow_cfg;
    mep_pkg::t_result pending_pixels[$];
    bit               gap_on;
    int               errors    = 0;
    int               n_pixels;
    int               n_writes;
    int               n_at_limit;
    int               n_checked = 0;
    int               cycles    = 0;

    mandelbrot_escape_pixel dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_pixel     (i_pixel),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // effective image side after the zero and oversize rules
    function automatic longint unsigned side_len(logic [mep_pkg::SIDE_W-1:0] v);
        if (v == 0) return 1;
        if (v > mep_pkg::MAX_SIDE) return mep_pkg::MAX_SIDE;
        return v;
    endfunction

    // clamp to the Q4 range
    function automatic longint clamp_q(longint v);
        longint hi;
        longint lo;
        hi = (64'sd8 <<< mep_pkg::FRAC_BITS) - 1;
        lo = -(64'sd8 <<< mep_pkg::FRAC_BITS);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // floor(num / den) in fixed point, capped at 16
    function automatic longint q_ratio(longint unsigned num, longint unsigned den);
        if (num / den >= 16) return 64'sd16 <<< mep_pkg::FRAC_BITS;
        return $signed((num << mep_pkg::FRAC_BITS) / den);
    endfunction

    // escape-time iteration for one pixel under a given configuration
    function automatic mep_pkg::t_result escape_time(mep_pkg::t_pixel p, mep_pkg::t_cfg c);
        longint unsigned  w;
        longint unsigned  h;
        longint unsigned  cnt;
        longint unsigned  scaled;
        longint           c_re;
        longint           c_im;
        longint           x;
        longint           y;
        longint           xx;
        longint           yy;
        longint           x_next;
        mep_pkg::t_result r;
        w    = side_len(c.image_width);
        h    = side_len(c.image_height);
        c_re = clamp_q(q_ratio(64'(p.pixel_col) * 7, w * 2)
                       - (64'sd5 <<< (mep_pkg::FRAC_BITS - 1)));
        c_im = clamp_q(q_ratio(64'(p.pixel_row) * 2, h) - (64'sd1 <<< mep_pkg::FRAC_BITS));
        x    = 0;
        y    = 0;
        cnt  = 0;
        while (cnt < 64'(c.iteration_limit)) begin
            xx = (x * x) >>> mep_pkg::FRAC_BITS;
            yy = (y * y) >>> mep_pkg::FRAC_BITS;
            if (xx + yy > (64'sd4 <<< mep_pkg::FRAC_BITS)) break;
            x_next = clamp_q(xx - yy + c_re);
            y      = clamp_q(((x * y) >>> (mep_pkg::FRAC_BITS - 1)) + c_im);
            x      = x_next;
            cnt++;
        end
        scaled = 0;
        if (c.iteration_limit != 0) begin
            scaled = cnt * 64'(c.gray_maximum) / 64'(c.iteration_limit);
        end
        r.pixel_gray   = mep_pkg::GW'(64'(c.gray_maximum) - scaled);
        r.escape_count = mep_pkg::GW'(cnt);
        return r;
    endfunction

    // random side: mostly regular, sometimes zero, tiny or oversized
    function automatic logic [mep_pkg::GW-1:0] pick_side();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return mep_pkg::GW'($urandom_range(mep_pkg::MAX_SIDE + 1, 65535));
            2, 3:    return mep_pkg::GW'($urandom_range(1, 16));
            default: return mep_pkg::GW'($urandom_range(1, mep_pkg::MAX_SIDE));
        endcase
    endfunction

    // register write beat; valid stays high for back-to-back writes
    task automatic write_reg(logic [mep_pkg::CFG_IDX_W-1:0] idx, logic [mep_pkg::GW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            mep_pkg::REG_WIDTH:  shadow_cfg.image_width     = mep_pkg::SIDE_W'(data);
            mep_pkg::REG_HEIGHT: shadow_cfg.image_height    = mep_pkg::SIDE_W'(data);
            mep_pkg::REG_GRAY:   shadow_cfg.gray_maximum    = data;
            mep_pkg::REG_LIMIT:  shadow_cfg.iteration_limit = data;
            default:             ;
        endcase
        n_writes++;
    endtask

    // pixel beat with random gaps; start stays high after the beat is taken
    task automatic send_pixel(mep_pkg::t_pixel p, bit use_given, mep_pkg::t_result given);
        mep_pkg::t_result want;
        i_cfg_valid <= 1'b0;
        while (gap_on && $urandom_range(0, 99) < GAP_PCT) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_pixel <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        want = use_given ? given : escape_time(p, shadow_cfg);
        pending_pixels.push_back(want);
        n_pixels++;
        if (shadow_cfg.iteration_limit != 0 && want.escape_count == shadow_cfg.iteration_limit)
            n_at_limit++;
    endtask

    // hold off until every pending result is back and the block is idle
    task automatic drain_results();
        start <= 1'b0;
        while (pending_pixels.size() != 0 || busy) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin : check_results
        mep_pkg::t_result want;
        if (i_rst_n && o_done) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result gray=%0d count=%0d", $time,
                         o_result.pixel_gray, o_result.escape_count);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                n_checked++;
                if (o_result.pixel_gray !== want.pixel_gray) begin
                    $display("%0t: pixel_gray expected %0d actual %0d", $time,
                             want.pixel_gray, o_result.pixel_gray);
                    errors++;
                end
                if (o_result.escape_count !== want.escape_count) begin
                    $display("%0t: escape_count expected %0d actual %0d", $time,
                             want.escape_count, o_result.escape_count);
                    errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached, %0d results outstanding",
                     $time, CYCLE_LIMIT, pending_pixels.size());
            $display("Verification failed");
            $finish;
        end
    end

    // stimulus
    initial begin : stimulus
        mep_pkg::t_pixel        px;
        mep_pkg::t_result       given;
        logic [mep_pkg::GW-1:0] lim;
        longint unsigned        w;
        longint unsigned        h;
        int                     n_items;
        n_pixels   = 0;
        n_writes   = 0;
        n_at_limit = 0;
        gap_on     = 1'b1;
        shadow_cfg = '{image_width: 13'd1000, image_height: 13'd1000,
                       gray_maximum: 16'd255, iteration_limit: 16'd1000};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (DIRECTED[i].kind == DO_WRITE) begin
                drain_results();
                write_reg(DIRECTED[i].idx, DIRECTED[i].data);
            end else begin
                px.pixel_row        = DIRECTED[i].row;
                px.pixel_col        = DIRECTED[i].col;
                given.pixel_gray    = DIRECTED[i].gray;
                given.escape_count  = DIRECTED[i].count;
                send_pixel(px, DIRECTED[i].known, given);
            end
        end

        // random phases, each under a fresh register setting
        for (int ph = 0; ph < 10; ph++) begin
            drain_results();
            write_reg(mep_pkg::REG_WIDTH, pick_side());
            write_reg(mep_pkg::REG_HEIGHT, pick_side());
            write_reg(mep_pkg::REG_GRAY,
                      ($urandom_range(0, 3) == 0) ? mep_pkg::GW'(255)
                                                  : mep_pkg::GW'($urandom_range(0, 65535)));
            // short limits keep the run fast; one phase at the default limit
            if (ph == 2) begin
                lim = 16'd1000;
            end else begin
                case ($urandom_range(0, 9))
                    0:          lim = '0;
                    1, 2, 3:    lim = mep_pkg::GW'($urandom_range(1, 8));
                    default:    lim = mep_pkg::GW'($urandom_range(9, 48));
                endcase
            end
            write_reg(mep_pkg::REG_LIMIT, lim);
            gap_on  = !(ph == 4 || ph == 5);
            n_items = (ph == 2) ? 20 : 63;
            w = side_len(shadow_cfg.image_width);
            h = side_len(shadow_cfg.image_height);
            for (int k = 0; k < n_items; k++) begin
                if ($urandom_range(0, 49) == 0) drain_results();
                // mostly pixels inside the image, some anywhere in the field range
                if ($urandom_range(0, 99) < 15) begin
                    px = mep_pkg::t_pixel'((2 * mep_pkg::PW)'($urandom));
                end else begin
                    px.pixel_row = mep_pkg::PW'($urandom_range(0, int'(h) - 1));
                    px.pixel_col = mep_pkg::PW'($urandom_range(0, int'(w) - 1));
                end
                send_pixel(px, 1'b0, '0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("checked %0d of %0d pixels across %0d register writes", n_checked,
                 n_pixels, n_writes);
        $display("%0d pixels ran to the iteration limit, %0d mismatches", n_at_limit, errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/mep_pkg.sv
rtl/mep_divider.sv
rtl/mep_sequencer.sv
rtl/mep_datapath.sv
rtl/mandelbrot_escape_pixel.sv
test/testbench.sv
